>>> sv/gszm_pkg.sv
// Shared types and constants for the GPS speed zone metrics block.
`timescale 1ns / 1ps

package gszm_pkg;

	localparam int SPEED_W = 16;
	localparam int TIME_W  = 32;
	localparam int DIST_W  = 48;
	localparam int AGE_W   = 16;
	localparam int SAT_W   = 6;
	localparam int HDOP_W  = 14;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int ZONES   = 5;
	localparam int ZONE_W  = 3;
	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 344;

	localparam int MIN_SATS_DEF   = 4;
	localparam int MAX_AGE_MS_DEF = 1500;

	localparam logic [ZONE_W-1:0] ZONE_0   = 3'd0;
	localparam logic [ZONE_W-1:0] ZONE_1   = 3'd1;
	localparam logic [ZONE_W-1:0] ZONE_2   = 3'd2;
	localparam logic [ZONE_W-1:0] ZONE_3   = 3'd3;
	localparam logic [ZONE_W-1:0] ZONE_TOP = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZONE_ONE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ZONE_TWO   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ZONE_THREE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ZONE_FOUR  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPRINT_MIN = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_HDOP   = 3'd7;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam logic [SPEED_W-1:0] COUNT_MAX = {SPEED_W{1'b1}};

	typedef struct packed {
		logic [SPEED_W-1:0] min_speed;
		logic [SPEED_W-1:0] max_gap;
		logic [SPEED_W-1:0] zone_one;
		logic [SPEED_W-1:0] zone_two;
		logic [SPEED_W-1:0] zone_three;
		logic [SPEED_W-1:0] zone_four;
		logic [SPEED_W-1:0] sprint_min;
		logic [HDOP_W-1:0]  max_hdop;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0]  time_ms;
		logic [SPEED_W-1:0] speed_cms;
		logic               location_valid;
		logic [AGE_W-1:0]   fix_age_ms;
		logic [SAT_W-1:0]   sat_count;
		logic               hdop_valid;
		logic [HDOP_W-1:0]  hdop_centi;
	} fix_t;

	typedef struct packed {
		logic               fix_ok;
		logic [SPEED_W-1:0] speed;
		logic [ZONE_W-1:0]  zone;
	} qual_t;

	typedef struct packed {
		logic               fix_ok;
		logic               session_started;
		logic [SPEED_W-1:0] cur_speed_cms;
		logic [DIST_W-1:0]  total_dist;
		logic [DIST_W-1:0]  zone0_dist;
		logic [DIST_W-1:0]  zone1_dist;
		logic [DIST_W-1:0]  zone2_dist;
		logic [DIST_W-1:0]  zone3_dist;
		logic [DIST_W-1:0]  zone4_dist;
		logic [SPEED_W-1:0] top_speed_cms;
		logic [SPEED_W-1:0] sprint_total;
	} result_t;

	function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
		input logic [TIME_W-1:0] b);
		logic [DIST_W:0] s;
		s = {1'b0, a} + {{(DIST_W+1-TIME_W){1'b0}}, b};
		return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
	endfunction

endpackage

>>> sv/gszm_qualify.sv
// Fix qualification, speed floor and speed zone selection.
`timescale 1ns / 1ps

module gszm_qualify #(
	parameter int MIN_SATS   = gszm_pkg::MIN_SATS_DEF,
	parameter int MAX_AGE_MS = gszm_pkg::MAX_AGE_MS_DEF
) (
	input  gszm_pkg::fix_t  fix,
	input  gszm_pkg::cfg_t  cfg,
	output gszm_pkg::qual_t qual
);
	import gszm_pkg::*;

	localparam logic [SAT_W-1:0] MIN_SATS_V  = SAT_W'(MIN_SATS);
	localparam logic [AGE_W-1:0] MAX_AGE_V   = AGE_W'(MAX_AGE_MS);

	logic               hdop_ok;
	logic [SPEED_W-1:0] v;

	always_comb begin
		hdop_ok = !fix.hdop_valid || (fix.hdop_centi <= cfg.max_hdop);
		qual.fix_ok = fix.location_valid && (fix.fix_age_ms < MAX_AGE_V) &&
			(fix.sat_count >= MIN_SATS_V) && hdop_ok;
		v = (fix.speed_cms < cfg.min_speed) ? '0 : fix.speed_cms;
		qual.speed = qual.fix_ok ? v : '0;
		// The bounds are tested in order, so bounds out of order are kept as given.
		priority if (v < cfg.zone_one) begin
			qual.zone = ZONE_0;
		end else if (v < cfg.zone_two) begin
			qual.zone = ZONE_1;
		end else if (v < cfg.zone_three) begin
			qual.zone = ZONE_2;
		end else if (v < cfg.zone_four) begin
			qual.zone = ZONE_3;
		end else begin
			qual.zone = ZONE_TOP;
		end
	end

endmodule

>>> sv/gszm_track.sv
// Session state: distance integration, zone sums, top speed and sprint count.
`timescale 1ns / 1ps

module gszm_track (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          update,
	input  logic [gszm_pkg::TIME_W-1:0]   now,
	input  gszm_pkg::qual_t               qual,
	input  gszm_pkg::cfg_t                cfg,
	output gszm_pkg::result_t             result
);
	import gszm_pkg::*;

	logic                started_q;
	logic [TIME_W-1:0]   last_time_q;
	logic [DIST_W-1:0]   total_q;
	logic [DIST_W-1:0]   zone_q [ZONES];
	logic [SPEED_W-1:0]  peak_q;
	logic [SPEED_W-1:0]  sprint_q;
	logic                in_top_q;
	logic                sprint_done_q;
	logic [TIME_W-1:0]   top_start_q;

	logic [TIME_W-1:0]   dt_raw;
	logic [SPEED_W-1:0]  dt;
	logic [TIME_W-1:0]   d;
	logic [DIST_W-1:0]   total_n;
	logic [DIST_W-1:0]   zone_n;
	logic [SPEED_W-1:0]  peak_n;
	logic [SPEED_W-1:0]  sprint_n;
	logic                in_top_n;
	logic                sprint_done_n;
	logic [TIME_W-1:0]   top_start_n;
	logic [TIME_W-1:0]   top_elapsed;
	logic                is_top;

	always_comb begin
		// On the first qualified fix the elapsed time is zero.
		dt_raw = started_q ? (now - last_time_q) : '0;
		dt = (dt_raw > {{(TIME_W-SPEED_W){1'b0}}, cfg.max_gap}) ? '0 : dt_raw[SPEED_W-1:0];
		d = qual.speed * dt;
		total_n = sat_add(total_q, d);
		zone_n = sat_add(zone_q[qual.zone], d);
		peak_n = (qual.speed > peak_q) ? qual.speed : peak_q;

		is_top = (qual.zone == ZONE_TOP);
		top_elapsed = now - top_start_q;
		sprint_n = sprint_q;
		in_top_n = in_top_q;
		sprint_done_n = sprint_done_q;
		top_start_n = top_start_q;
		if (is_top) begin
			if (!in_top_q) begin
				in_top_n = 1'b1;
				sprint_done_n = 1'b0;
				top_start_n = now;
			end else if (!sprint_done_q &&
				top_elapsed >= {{(TIME_W-SPEED_W){1'b0}}, cfg.sprint_min}) begin
				sprint_n = (sprint_q == COUNT_MAX) ? sprint_q : sprint_q + 1'b1;
				sprint_done_n = 1'b1;
			end
		end else begin
			in_top_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			last_time_q <= '0;
			total_q <= '0;
			for (int i = 0; i < ZONES; i++) zone_q[i] <= '0;
			peak_q <= '0;
			sprint_q <= '0;
			in_top_q <= 1'b0;
			sprint_done_q <= 1'b0;
			top_start_q <= '0;
		end else if (update && qual.fix_ok) begin
			started_q <= 1'b1;
			last_time_q <= now;
			total_q <= total_n;
			zone_q[qual.zone] <= zone_n;
			peak_q <= peak_n;
			sprint_q <= sprint_n;
			in_top_q <= in_top_n;
			sprint_done_q <= sprint_done_n;
			top_start_q <= top_start_n;
		end
	end

	// Result of the current item, as seen after its own update.
	always_comb begin
		result.fix_ok = qual.fix_ok;
		result.session_started = started_q || qual.fix_ok;
		result.cur_speed_cms = qual.speed;
		result.total_dist = qual.fix_ok ? total_n : total_q;
		result.zone0_dist = (qual.fix_ok && qual.zone == ZONE_0) ? zone_n : zone_q[0];
		result.zone1_dist = (qual.fix_ok && qual.zone == ZONE_1) ? zone_n : zone_q[1];
		result.zone2_dist = (qual.fix_ok && qual.zone == ZONE_2) ? zone_n : zone_q[2];
		result.zone3_dist = (qual.fix_ok && qual.zone == ZONE_3) ? zone_n : zone_q[3];
		result.zone4_dist = (qual.fix_ok && qual.zone == ZONE_TOP) ? zone_n : zone_q[4];
		result.top_speed_cms = qual.fix_ok ? peak_n : peak_q;
		result.sprint_total = qual.fix_ok ? sprint_n : sprint_q;
	end

endmodule

>>> sv/gps_speed_zone_metrics.sv
// Top level of the GPS speed zone metrics block.
// Usage:
// Fix reports enter on the s_axis channel, one request per report, and each
// report yields exactly one metrics result on the m_axis channel.
// Configuration registers are written through cfg_we, cfg_index and cfg_data
// while the block is idle; a write takes effect at the same clock edge.
// A request accepted at one edge is held in an input register; the session
// state update and the result register load happen together once the result
// register is empty or its result is being taken, so each result is registered.
// Throughput is one report per cycle: the input register advances whenever
// the result register is empty or its result is being taken in that cycle.
// The single 16x16 distance multiply and the two 48-bit saturating adds lie
// between the input register and the result register.
// When the receiver stalls, the result stays on m_axis_tdata, the input
// register fills, and s_axis_tready drops until the result is taken.
// Reset clears all accumulators, the session and sprint tracking, both
// valid flags, and loads every configuration register with its default.
`timescale 1ns / 1ps

module gps_speed_zone_metrics #(
	parameter int MIN_SATS   = gszm_pkg::MIN_SATS_DEF,
	parameter int MAX_AGE_MS = gszm_pkg::MAX_AGE_MS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// time_ms, speed_cms, location_valid, fix_age_ms, sat_count, hdop_valid, hdop_centi
	input  logic [gszm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// fix_ok, session_started, cur_speed_cms, total_dist, zone0_dist .. zone4_dist,
	// top_speed_cms, sprint_total
	output logic [gszm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input  logic                              cfg_we,
	input  logic [gszm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gszm_pkg::CFG_W-1:0]        cfg_data
);
	import gszm_pkg::*;

	cfg_t    cfg_q;
	fix_t    fix_s1;
	logic    valid_s1;
	result_t result_s2;
	logic    valid_s2;
	qual_t   qual;
	result_t result;
	logic    out_free;
	logic    advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_speed  <= 16'd50;
			cfg_q.max_gap    <= 16'd2000;
			cfg_q.zone_one   <= 16'd194;
			cfg_q.zone_two   <= 16'd400;
			cfg_q.zone_three <= 16'd550;
			cfg_q.zone_four  <= 16'd700;
			cfg_q.sprint_min <= 16'd1000;
			cfg_q.max_hdop   <= 14'd500;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_SPEED:  cfg_q.min_speed  <= cfg_data;
				REG_MAX_GAP:    cfg_q.max_gap    <= cfg_data;
				REG_ZONE_ONE:   cfg_q.zone_one   <= cfg_data;
				REG_ZONE_TWO:   cfg_q.zone_two   <= cfg_data;
				REG_ZONE_THREE: cfg_q.zone_three <= cfg_data;
				REG_ZONE_FOUR:  cfg_q.zone_four  <= cfg_data;
				REG_SPRINT_MIN: cfg_q.sprint_min <= cfg_data;
				REG_MAX_HDOP:   cfg_q.max_hdop   <= cfg_data[HDOP_W-1:0];
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	assign out_free = !valid_s2 || m_axis_tready;
	assign advance = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) valid_s1 <= s_axis_tvalid;
			if (out_free) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			fix_s1.time_ms        <= s_axis_tdata[31:0];
			fix_s1.speed_cms      <= s_axis_tdata[47:32];
			fix_s1.location_valid <= s_axis_tdata[48];
			fix_s1.fix_age_ms     <= s_axis_tdata[64:49];
			fix_s1.sat_count      <= s_axis_tdata[70:65];
			fix_s1.hdop_valid     <= s_axis_tdata[71];
			fix_s1.hdop_centi     <= s_axis_tdata[85:72];
		end
		if (advance) result_s2 <= result;
	end

	gszm_qualify #(
		.MIN_SATS   (MIN_SATS),
		.MAX_AGE_MS (MAX_AGE_MS)
	) u_qualify (
		.fix  (fix_s1),
		.cfg  (cfg_q),
		.qual (qual)
	);

	gszm_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.update (advance),
		.now    (fix_s1.time_ms),
		.qual   (qual),
		.cfg    (cfg_q),
		.result (result)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata = {6'd0,
		result_s2.sprint_total,
		result_s2.top_speed_cms,
		result_s2.zone4_dist,
		result_s2.zone3_dist,
		result_s2.zone2_dist,
		result_s2.zone1_dist,
		result_s2.zone0_dist,
		result_s2.total_dist,
		result_s2.cur_speed_cms,
		result_s2.session_started,
		result_s2.fix_ok};

endmodule
